// ===== design/sorted_check_table_insert_unit_defines.svh =====
// assertion macros for the sorted check table insert unit
`ifndef SORTED_CHECK_TABLE_INSERT_UNIT_DEFINES_SVH
`define SORTED_CHECK_TABLE_INSERT_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define SCT_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define SCT_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sct_pkg.sv =====
// shared types and constants for the sorted check table insert unit
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W  = 62;
  localparam int ID_W   = 64;
  localparam int ATTR_W = 12;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // key is {packet_count, send_interval, packet_size, wait_timeout}
  // attr is {host_ref, check_kind, stat_mode}
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ID_W-1:0]   id;
    logic [ATTR_W-1:0] attr;
  } entry_t;

  typedef struct packed {
    logic ins_en;
    logic occupied;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/sct_cell.sv =====
// one table slot: compares its key with the new key and shifts on insert
`timescale 1ns / 1ps
`default_nettype none

module sct_cell (
  input  logic              clk,
  input  sct_pkg::cell_ctl_t ctl,
  input  sct_pkg::entry_t   new_entry,
  input  sct_pkg::entry_t   left_entry,
  input  logic              left_less,
  output logic              less,
  output logic              here,
  output sct_pkg::entry_t   entry
);
  import sct_pkg::*;

  assign less = ctl.occupied && (entry.key < new_entry.key);
  // first slot whose key is not smaller takes the new entry
  assign here = !less && left_less;

  always_ff @(posedge clk) begin
    if (ctl.ins_en && !less) begin
      entry <= left_less ? new_entry : left_entry;
    end
  end

endmodule

`default_nettype wire

// ===== design/sorted_check_table_insert_unit.sv =====
// top level: sorted check table built as a chain of compare-and-shift cells
//
//  port group     direction  handshake             payload
//  command item   in         start / busy          command, key fields, item data, read_index
//  result item    out        done (one-cycle pulse) status, position, entry_total, out_*
//
// each command passes through ST_IDLE, where start with busy low latches the item,
// and ST_EXEC, where busy is high, all cells update at once and the result is
// registered; done is high in the cycle after ST_EXEC.
// the cell chain compares every slot against the new key in parallel, so an
// insert costs the same as a read or a clear.
// rst is synchronous and empties the table; slot contents are not cleared.
// the receiver cannot stall; done pulses for one cycle, results hold until the next command.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_check_table_insert_unit_defines.svh"

module sorted_check_table_insert_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [13:0] packet_count,
  input  logic [15:0] send_interval,
  input  logic [15:0] packet_size,
  input  logic [15:0] wait_timeout,
  input  logic [63:0] item_id,
  input  logic [7:0]  host_ref,
  input  logic [1:0]  check_kind,
  input  logic [1:0]  stat_mode,
  input  logic [6:0]  read_index,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  position,
  output logic [7:0]  entry_total,
  output logic [13:0] out_packet_count,
  output logic [15:0] out_send_interval,
  output logic [15:0] out_packet_size,
  output logic [15:0] out_wait_timeout,
  output logic [63:0] out_item_id,
  output logic [7:0]  out_host_ref,
  output logic [1:0]  out_check_kind,
  output logic [1:0]  out_stat_mode
);
  import sct_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;

  cmd_t       cmd_q;
  entry_t     new_q;
  logic [6:0] rd_idx_q;

  entry_t           cell_data [TABLE_DEPTH];
  cell_ctl_t        cell_ctl  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] less;
  logic [TABLE_DEPTH-1:0] here;
  logic [TABLE_DEPTH-1:0] rd_sel;

  logic             full;
  logic             ins_en;
  logic             rd_ok;
  logic [IDX_W-1:0] ins_pos;
  entry_t           rd_entry;

  status_t    status_next;
  logic [7:0] position_next;
  entry_t     out_entry_next;

  assign busy   = (state == ST_EXEC);
  assign full   = (count == CNT_W'(TABLE_DEPTH));
  assign ins_en = (state == ST_EXEC) && (cmd_q == CMD_INSERT) && !full;
  assign rd_ok  = (32'(rd_idx_q) < 32'(count));

  // item latch
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q    <= cmd_t'(command);
      new_q    <= '{key:  {packet_count, send_interval, packet_size, wait_timeout},
                    id:   item_id,
                    attr: {host_ref, check_kind, stat_mode}};
      rd_idx_q <= read_index;
    end
  end

  // cell chain
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign cell_ctl[i] = '{ins_en: ins_en, occupied: (32'(count) > i)};
    assign rd_sel[i]   = (32'(rd_idx_q) == i);

    if (i == 0) begin : g_head
      sct_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .new_entry  (new_q),
        .left_entry (new_q),
        .left_less  (1'b1),
        .less       (less[i]),
        .here       (here[i]),
        .entry      (cell_data[i])
      );
    end else begin : g_body
      sct_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .new_entry  (new_q),
        .left_entry (cell_data[i-1]),
        .left_less  (less[i-1]),
        .less       (less[i]),
        .here       (here[i]),
        .entry      (cell_data[i])
      );
    end
  end

  // one-hot insert slot to index, one-hot read select to data
  always_comb begin
    ins_pos  = '0;
    rd_entry = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (here[i]) begin
        ins_pos = ins_pos | IDX_W'(i);
      end
      if (rd_sel[i]) begin
        rd_entry = rd_entry | cell_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == ST_EXEC);
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    status_next    = STAT_DONE;
    position_next  = '0;
    out_entry_next = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (cmd_q)
          CMD_INSERT: begin
            if (full) begin
              status_next = STAT_FULL;
            end else begin
              count_next    = count + CNT_W'(1);
              position_next = 8'(ins_pos);
            end
          end
          CMD_READ: begin
            position_next = 8'(rd_idx_q);
            if (rd_ok) begin
              out_entry_next = rd_entry;
            end else begin
              status_next = STAT_RANGE;
            end
          end
          CMD_CLEAR: begin
            count_next = '0;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      status            <= status_next;
      position          <= position_next;
      entry_total       <= 8'(count_next);
      out_packet_count  <= out_entry_next.key[61:48];
      out_send_interval <= out_entry_next.key[47:32];
      out_packet_size   <= out_entry_next.key[31:16];
      out_wait_timeout  <= out_entry_next.key[15:0];
      out_item_id       <= out_entry_next.id;
      out_host_ref      <= out_entry_next.attr[11:4];
      out_check_kind    <= out_entry_next.attr[3:2];
      out_stat_mode     <= out_entry_next.attr[1:0];
    end
  end

  `SCT_CHECK_NEXT(a_exec_gives_result, busy, done && !busy, "no result after execute cycle")
  `SCT_CHECK(a_insert_one_slot, ins_en, $onehot(here), "insert slot not unique")
  `SCT_CHECK(a_count_bound, 1'b1, count <= CNT_W'(TABLE_DEPTH), "entry count above depth")
  `SCT_CHECK(a_full_total, done && (status == STAT_FULL), entry_total == 8'(TABLE_DEPTH),
             "full status with table not full")

endmodule

`default_nettype wire
